// ===== design/ihhr_pkg.sv =====
`default_nettype none
package ihhr_pkg;

  localparam int unsigned NUM_BINS   = 14;
  localparam int unsigned BIN_W      = 4;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned HR_W       = 16;
  localparam int unsigned EDGE_W     = 12;
  localparam int unsigned EDGE_MAX   = 3200;
  localparam int unsigned RATE_NUM_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [RATE_NUM_W-1:0] RATE_NUM = 24'd15360000;
  localparam logic [HR_W-1:0]       HR_RESET = 16'd18432;
  localparam logic [HR_W-1:0]       HR_MAX   = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SINGLE,
    CFG_WINDOW,
    CFG_MISSING,
    CFG_TOL
  } cfg_idx_e;

  typedef enum logic [1:0] {
    METH_NONE,
    METH_SINGLE,
    METH_DOUBLE,
    METH_TRIPLE
  } method_e;

  typedef logic [EDGE_W-1:0] edge_t;

  localparam edge_t BIN_EDGE [NUM_BINS] = '{
    12'd400, 12'd450, 12'd500, 12'd600, 12'd700, 12'd800, 12'd900,
    12'd1000, 12'd1200, 12'd1600, 12'd2000, 12'd2400, 12'd2800, 12'd3200
  };

  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] idx;
  } bin_t;

  function automatic bin_t find_bin(input logic [IN_W-1:0] d);
    bin_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int k = NUM_BINS - 1; k >= 0; k--) begin
      if (d <= IN_W'(BIN_EDGE[k])) begin
        r.hit = 1'b1;
        r.idx = BIN_W'(k);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ihhr_intf.sv =====
`default_nettype none
interface ihhr_beat_if import ihhr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] beat_time_ms;
  modport source (output valid, beat_time_ms, input ready);
  modport sink (input valid, beat_time_ms, output ready);
endinterface

interface ihhr_rate_if import ihhr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [HR_W-1:0] hr_q8;
  logic            dropped;
  logic [1:0]      method;
  modport source (output valid, hr_q8, dropped, method, input ready);
  modport sink (input valid, hr_q8, dropped, method, output ready);
endinterface

interface ihhr_cfg_if import ihhr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/interval_histogram_heart_rate_unit.sv =====
`default_nettype none
// Heart-rate estimator: each request carries one beat timestamp (ms) and yields one result with
// the rate in bpm Q8.8, a dropped flag and the majority method. Intervals go into 14 fixed bins
// kept over a ring of the last RING_DEPTH intervals. One request is worked at a time; ready is
// low while it runs. A dropped interval skips the bins and goes straight to the result.
// Otherwise bookkeeping, a scan over the 14 bins and a sum over the window bins follow, and
// every rate goes through one shared restoring divider of NW quotient bits
// (NW = 24 + clog2(6*RING_DEPTH+1), 32 at depth 30): one division for the window and up to
// four per bin tried for missing-beat compensation; an item with no majority skips the divider.
module interval_histogram_heart_rate_unit import ihhr_pkg::*; #(
  parameter int unsigned RING_DEPTH = 30
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ihhr_beat_if.sink   beat_i,
  ihhr_rate_if.source rate_o,
  ihhr_cfg_if.sink    cfg_i
);

  localparam int unsigned PW   = $clog2(RING_DEPTH);
  localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW   = $clog2(RING_DEPTH * EDGE_MAX + 1);
  localparam int unsigned NAW  = $clog2(6 * RING_DEPTH + 1);
  localparam int unsigned SAW  = $clog2(3 * RING_DEPTH * EDGE_MAX + 1);
  localparam int unsigned NW   = NAW + RATE_NUM_W;
  localparam int unsigned DCW  = $clog2(NW);
  localparam int unsigned VW   = (CW + 2 > 5) ? CW + 2 : 5;
  localparam logic [BIN_W-1:0] LAST = BIN_W'(NUM_BINS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BIN, S_OLD, S_ADD, S_SCAN, S_PICK, S_WSUM, S_WEND,
    S_COMP, S_MUL, S_DIV, S_POST, S_FIN, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    P_WIN, P_TWO, P_TWO_UPD, P_THREE, P_THREE_UPD
  } pur_e;

  state_e            state_q;
  pur_e              pur_q;
  logic [4:0]        smc_q, wmc_q, mbc_q;
  logic [5:0]        tol_q;
  logic [IN_W-1:0]   prev_q;
  logic [HR_W-1:0]   last_q;
  logic [CW-1:0]     count_q [NUM_BINS];
  logic [SW-1:0]     sum_q [NUM_BINS];
  logic [PW-1:0]     pos_q;
  logic [CW-1:0]     fill_q;
  logic [BIN_W-1:0]  k_q, i_q, idx_q, hi_q;
  logic [EDGE_W-1:0] d_q;
  logic              drop_q;
  method_e           method_q;
  logic [CW-1:0]     c1_q, c2_q;
  logic              sgl_q, dbl_q, tri_q;
  logic [BIN_W-1:0]  sgl_idx_q, dbl_idx_q, tri_idx_q;
  logic [VW-1:0]     dbl_v_q, tri_v_q;
  logic [NAW-1:0]    n_q, kn_q;
  logic [SAW-1:0]    s_q, den_q;
  logic [NW-1:0]     hr_q;
  logic              inf_q;
  logic [CW-1:0]     c_q;
  logic [SW-1:0]     b_q;
  logic [NW-1:0]     dq_q;
  logic [SAW-1:0]    rem_q;
  logic [DCW-1:0]    dcnt_q;
  logic              ov_q;
  logic [HR_W-1:0]   ohr_q;
  logic              odrop_q;
  method_e           ometh_q;

  logic [IN_W-1:0]   dfull;
  bin_t              fb, ob;
  logic [EDGE_W-1:0] ram_rdata;
  logic [CW-1:0]     cur;
  logic [SW-1:0]     cur_sum;
  logic [VW-1:0]     v1, v2, v3;
  logic [SAW:0]      trial;
  logic              ge;
  logic [NW-1:0]     diff;
  logic              match;
  logic [NAW-1:0]    c2x, c3x;
  logic [BIN_W-1:0]  lo_s, hi_s, lo_d, hi_d;

  always_comb begin
    dfull   = beat_i.beat_time_ms - prev_q;
    fb      = find_bin(dfull);
    ob      = find_bin(IN_W'(ram_rdata));
    cur     = count_q[i_q];
    cur_sum = sum_q[i_q];
    v1      = VW'(cur);
    v2      = VW'(c1_q) + VW'(cur);
    v3      = VW'(c2_q) + VW'(c1_q) + VW'(cur);
    trial   = {rem_q, dq_q[NW-1]};
    ge      = trial >= {1'b0, den_q};
    diff    = (dq_q > hr_q) ? (dq_q - hr_q) : (hr_q - dq_q);
    match   = !inf_q && (diff < NW'({tol_q, 8'h00}));
    c2x     = NAW'(c_q) << 1;
    c3x     = NAW'(c_q) + (NAW'(c_q) << 1);
    lo_s    = (sgl_idx_q == '0) ? '0 : sgl_idx_q - 1'b1;
    hi_s    = (sgl_idx_q == LAST) ? sgl_idx_q : sgl_idx_q + 1'b1;
    lo_d    = dbl_idx_q - 1'b1;
    hi_d    = (dbl_idx_q == LAST) ? dbl_idx_q : dbl_idx_q + 1'b1;
  end

  assign beat_i.ready   = (state_q == S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign rate_o.valid   = ov_q;
  assign rate_o.hr_q8   = ohr_q;
  assign rate_o.dropped = odrop_q;
  assign rate_o.method  = ometh_q;

  ihhr_ram #(
    .WIDTH(EDGE_W),
    .DEPTH(RING_DEPTH)
  ) u_ihhr_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == S_ADD),
    .addr_i  (pos_q),
    .wdata_i (d_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pur_q     <= P_WIN;
      smc_q     <= 5'd20;
      wmc_q     <= 5'd15;
      mbc_q     <= 5'd3;
      tol_q     <= 6'd15;
      prev_q    <= '0;
      last_q    <= HR_RESET;
      for (int b = 0; b < NUM_BINS; b++) begin
        count_q[b] <= '0;
        sum_q[b]   <= '0;
      end
      pos_q     <= '0;
      fill_q    <= '0;
      k_q       <= '0;
      i_q       <= '0;
      idx_q     <= '0;
      hi_q      <= '0;
      d_q       <= '0;
      drop_q    <= 1'b0;
      method_q  <= METH_NONE;
      c1_q      <= '0;
      c2_q      <= '0;
      sgl_q     <= 1'b0;
      dbl_q     <= 1'b0;
      tri_q     <= 1'b0;
      sgl_idx_q <= '0;
      dbl_idx_q <= '0;
      tri_idx_q <= '0;
      dbl_v_q   <= '0;
      tri_v_q   <= '0;
      n_q       <= '0;
      kn_q      <= '0;
      s_q       <= '0;
      den_q     <= '0;
      hr_q      <= '0;
      inf_q     <= 1'b0;
      c_q       <= '0;
      b_q       <= '0;
      dq_q      <= '0;
      rem_q     <= '0;
      dcnt_q    <= '0;
      ov_q      <= 1'b0;
      ohr_q     <= '0;
      odrop_q   <= 1'b0;
      ometh_q   <= METH_NONE;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_SINGLE:  smc_q <= cfg_i.data[4:0];
          CFG_WINDOW:  wmc_q <= cfg_i.data[4:0];
          CFG_MISSING: mbc_q <= cfg_i.data[4:0];
          CFG_TOL:     tol_q <= cfg_i.data[5:0];
          default:     smc_q <= smc_q;
        endcase
      end
      if (rate_o.ready && state_q != S_DONE) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (beat_i.valid) begin
            prev_q <= beat_i.beat_time_ms;
            k_q    <= fb.idx;
            d_q    <= dfull[EDGE_W-1:0];
            if (!fb.hit) begin
              drop_q   <= 1'b1;
              method_q <= METH_NONE;
              state_q  <= S_DONE;
            end else begin
              drop_q  <= 1'b0;
              state_q <= S_BIN;
            end
          end
        end
        S_BIN: begin
          if (fill_q == CW'(RING_DEPTH)) begin
            state_q <= S_OLD;
          end else begin
            fill_q  <= fill_q + 1'b1;
            state_q <= S_ADD;
          end
        end
        S_OLD: begin
          if (ob.hit && count_q[ob.idx] != '0) begin
            count_q[ob.idx] <= count_q[ob.idx] - 1'b1;
            sum_q[ob.idx]   <= (sum_q[ob.idx] >= SW'(ram_rdata)) ?
                               sum_q[ob.idx] - SW'(ram_rdata) : '0;
          end
          state_q <= S_ADD;
        end
        S_ADD: begin
          count_q[k_q] <= count_q[k_q] + 1'b1;
          sum_q[k_q]   <= sum_q[k_q] + SW'(d_q);
          pos_q        <= (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
          i_q          <= '0;
          sgl_q        <= 1'b0;
          dbl_q        <= 1'b0;
          tri_q        <= 1'b0;
          dbl_v_q      <= '0;
          tri_v_q      <= '0;
          state_q      <= S_SCAN;
        end
        S_SCAN: begin
          if (!sgl_q && v1 >= VW'(smc_q) && v1 != '0) begin
            sgl_q     <= 1'b1;
            sgl_idx_q <= i_q;
          end
          if (i_q != '0 && !dbl_q && v2 >= VW'(wmc_q) && v2 != '0) begin
            dbl_q     <= 1'b1;
            dbl_idx_q <= i_q;
            dbl_v_q   <= v2;
          end
          if (i_q > BIN_W'(1) && !tri_q && v3 >= VW'(wmc_q) && v3 != '0) begin
            tri_q     <= 1'b1;
            tri_idx_q <= i_q;
            tri_v_q   <= v3;
          end
          c1_q <= cur;
          c2_q <= c1_q;
          if (i_q == LAST) begin
            state_q <= S_PICK;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_PICK: begin
          n_q <= '0;
          s_q <= '0;
          if (sgl_q) begin
            method_q <= METH_SINGLE;
            idx_q    <= sgl_idx_q;
            i_q      <= lo_s;
            hi_q     <= hi_s;
            state_q  <= S_WSUM;
          end else if (!dbl_q && !tri_q) begin
            method_q <= METH_NONE;
            state_q  <= S_DONE;
          end else if (dbl_v_q >= tri_v_q) begin
            method_q <= METH_DOUBLE;
            idx_q    <= dbl_idx_q;
            i_q      <= lo_d;
            hi_q     <= hi_d;
            state_q  <= S_WSUM;
          end else begin
            method_q <= METH_TRIPLE;
            idx_q    <= tri_idx_q;
            i_q      <= tri_idx_q - BIN_W'(2);
            hi_q     <= tri_idx_q;
            state_q  <= S_WSUM;
          end
        end
        S_WSUM: begin
          n_q <= n_q + NAW'(cur);
          s_q <= s_q + SAW'(cur_sum);
          if (i_q == hi_q) begin
            state_q <= S_WEND;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_WEND: begin
          i_q <= idx_q;
          if (s_q == '0) begin
            inf_q   <= 1'b1;
            state_q <= S_COMP;
          end else begin
            inf_q   <= 1'b0;
            kn_q    <= n_q;
            den_q   <= s_q;
            pur_q   <= P_WIN;
            state_q <= S_MUL;
          end
        end
        S_COMP: begin
          if (VW'(cur) > VW'(mbc_q) && cur_sum != '0) begin
            c_q     <= cur;
            b_q     <= cur_sum;
            kn_q    <= NAW'(cur) << 1;
            den_q   <= SAW'(cur_sum);
            pur_q   <= P_TWO;
            state_q <= S_MUL;
          end else if (i_q == LAST) begin
            state_q <= S_FIN;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_MUL: begin
          dq_q    <= NW'(RATE_NUM) * NW'(kn_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem_q <= SAW'(trial - {1'b0, den_q});
          end else begin
            rem_q <= trial[SAW-1:0];
          end
          dq_q   <= {dq_q[NW-2:0], ge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCW'(NW - 1)) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          case (pur_q)
            P_WIN: begin
              hr_q    <= dq_q;
              inf_q   <= 1'b0;
              state_q <= S_COMP;
            end
            P_TWO: begin
              if (match) begin
                s_q   <= s_q + SAW'(b_q);
                n_q   <= n_q + c2x;
                kn_q  <= n_q + c2x;
                den_q <= s_q + SAW'(b_q);
                pur_q <= P_TWO_UPD;
              end else begin
                kn_q  <= c3x;
                den_q <= SAW'(b_q);
                pur_q <= P_THREE;
              end
              state_q <= S_MUL;
            end
            P_TWO_UPD: begin
              hr_q    <= dq_q;
              inf_q   <= 1'b0;
              kn_q    <= c3x;
              den_q   <= SAW'(b_q);
              pur_q   <= P_THREE;
              state_q <= S_MUL;
            end
            P_THREE: begin
              if (match) begin
                s_q     <= s_q + SAW'(b_q);
                n_q     <= n_q + c3x;
                kn_q    <= n_q + c3x;
                den_q   <= s_q + SAW'(b_q);
                pur_q   <= P_THREE_UPD;
                state_q <= S_MUL;
              end else if (i_q == LAST) begin
                state_q <= S_FIN;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= S_COMP;
              end
            end
            default: begin
              hr_q  <= dq_q;
              inf_q <= 1'b0;
              if (i_q == LAST) begin
                state_q <= S_FIN;
              end else begin
                i_q     <= i_q + 1'b1;
                state_q <= S_COMP;
              end
            end
          endcase
        end
        S_FIN: begin
          last_q  <= (inf_q || hr_q > NW'(HR_MAX)) ? HR_MAX : hr_q[HR_W-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!ov_q || rate_o.ready) begin
            ov_q    <= 1'b1;
            ohr_q   <= last_q;
            odrop_q <= drop_q;
            ometh_q <= method_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ihhr_ram.sv =====
`default_nettype none
module ihhr_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 30
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== design/ihhr_checker.sv =====
`default_nettype none
module ihhr_checker import ihhr_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [HR_W-1:0] hr_q8_i,
  input wire logic            dropped_i,
  input wire logic [1:0]      method_i
);

  a_drop_no_method: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && dropped_i) |-> (method_i == METH_NONE))
    else $error("dropped result carries a method");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("ready held high after a request");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(hr_q8_i)))
    else $error("stalled result changed");

endmodule

bind interval_histogram_heart_rate_unit ihhr_checker u_ihhr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (beat_i.valid),
  .in_ready_i  (beat_i.ready),
  .out_valid_i (rate_o.valid),
  .out_ready_i (rate_o.ready),
  .hr_q8_i     (rate_o.hr_q8),
  .dropped_i   (rate_o.dropped),
  .method_i    (rate_o.method)
);
`default_nettype wire
